>>> hw/rtl/arpbt_pkg.sv
// Shared constants and types for the ARP binding table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package arpbt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = 5;
  localparam int SLOT_W  = 4;
  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;

  // operation codes
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_FIND   = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ipv4;
  } entry_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } free_t;

endpackage

>>> hw/rtl/arpbt_free_enc.sv
// Lowest-free-slot priority encoder over the slot valid bits.
// Depends on arpbt_pkg.
`timescale 1ns / 1ps

module arpbt_free_enc (
  input  logic [arpbt_pkg::ENTRIES-1:0] valid_i,
  output arpbt_pkg::free_t              free_o
);
  import arpbt_pkg::*;

  always_comb begin
    free_o = '0;
    // walk from the top so the lowest free slot wins
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_i[i]) begin
        free_o.found = 1'b1;
        free_o.idx   = IDX_W'(i);
      end
    end
  end

endmodule

>>> hw/rtl/arp_binding_table_unit.sv
// Top level of the ARP binding table: command decode, valid bits, entry memory
// and the sequential find scan. Depends on arpbt_pkg and arpbt_free_enc.
`timescale 1ns / 1ps

// Usage
//   Input: present func, mac_addr, ipv4_addr and slot on the in_ ports and
//   raise start. The transfer happens at the edge where start is high and busy
//   is low; hold nothing after that, the block latches what it needs.
//   Output: every command gives exactly one result. out_valid is high for one
//   cycle with status, slot_index and entry_count; that cycle is the transfer.
//   The receiver cannot stall, so results are never held back.
// Command timing
//   Add, remove and the unused code: result in the cycle after the transfer,
//   and a new command may be issued in that same result cycle.
//   Find: the pair memory is scanned one slot per cycle through its single
//   registered read port, stopping at the first hit; the result is registered
//   once a slot hits or the last slot has been compared. busy is high during
//   the scan.
// Reset
//   rst_n low (synchronous) clears all valid bits and the entry count. The
//   address memory is not cleared: a slot only counts in a find once its
//   valid bit is set; no clearing pass, commands are taken right after reset.

module arp_binding_table_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_func,
  input  logic [arpbt_pkg::MAC_W-1:0]    in_mac_addr,
  input  logic [arpbt_pkg::IP_W-1:0]     in_ipv4_addr,
  input  logic [arpbt_pkg::SLOT_W-1:0]   in_slot,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [arpbt_pkg::SLOT_W-1:0]   out_slot_index,
  output logic [arpbt_pkg::CNT_W-1:0]    out_entry_count
);
  import arpbt_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  // control state
  logic                 state_r, state_nxt;
  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // payload registers
  logic [1:0]           status_r, status_nxt;
  logic [SLOT_W-1:0]    index_r, index_nxt;
  entry_t               key_r, key_nxt;

  // entry memory: one write port, one registered read port
  entry_t               mem [ENTRIES];
  entry_t               rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;

  free_t                free;
  logic                 accept;
  logic [IDX_W-1:0]     rm_idx;
  logic                 rm_in_range;
  logic                 hit;

  arpbt_free_enc u_free_enc (
    .valid_i (valid_r),
    .free_o  (free)
  );

  assign accept      = start && (state_r == S_IDLE);
  assign rm_idx      = IDX_W'(in_slot);
  assign rm_in_range = (int'(in_slot) < ENTRIES);
  assign hit         = valid_r[scan_idx_r] && (rd_data_r == key_r);

  // Read slot 0 on the accept edge, then one slot ahead of the compare.
  assign rd_addr = (state_r == S_SCAN) ? scan_idx_r + IDX_W'(1) : '0;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    index_nxt     = index_r;
    key_nxt       = key_r;
    wr_en         = 1'b0;
    wr_addr       = free.idx;
    wr_data       = '{mac: in_mac_addr, ipv4: in_ipv4_addr};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_ADD: begin
              out_valid_nxt = 1'b1;
              if (free.found) begin
                // write the pair straight into the lowest free slot
                wr_en                = 1'b1;
                valid_nxt[free.idx]  = 1'b1;
                count_nxt            = count_r + CNT_W'(1);
                status_nxt           = ST_OK;
                index_nxt            = SLOT_W'(free.idx);
              end else begin
                status_nxt = ST_FULL;
                index_nxt  = '0;
              end
            end
            FUNC_FIND: begin
              // latch the key and start the scan at slot 0
              key_nxt      = '{mac: in_mac_addr, ipv4: in_ipv4_addr};
              scan_idx_nxt = '0;
              state_nxt    = S_SCAN;
            end
            FUNC_REMOVE: begin
              out_valid_nxt = 1'b1;
              if (rm_in_range && valid_r[rm_idx]) begin
                valid_nxt[rm_idx] = 1'b0;
                count_nxt         = count_r - CNT_W'(1);
                status_nxt        = ST_OK;
                index_nxt         = in_slot;
              end else begin
                status_nxt = ST_EMPTY;
                index_nxt  = '0;
              end
            end
            default: begin
              // unused code: report the count, change nothing
              out_valid_nxt = 1'b1;
              status_nxt    = ST_OK;
              index_nxt     = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          index_nxt     = SLOT_W'(scan_idx_r);
          state_nxt     = S_IDLE;
        end else if (int'(scan_idx_r) == ENTRIES - 1) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_NOT_FOUND;
          index_nxt     = '0;
          state_nxt     = S_IDLE;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      scan_idx_r  <= scan_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    index_r  <= index_nxt;
    key_r    <= key_nxt;
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_slot_index  = index_r;
  assign out_entry_count = count_r;

endmodule

>>> hw/rtl/arpbt_checker.sv
// Port-level checks for the ARP binding table, bound to the top level.
// Depends on arpbt_pkg and arp_binding_table_unit.
`timescale 1ns / 1ps

module arpbt_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic                          out_valid,
  input  logic [1:0]                    out_status,
  input  logic [arpbt_pkg::SLOT_W-1:0]  out_slot_index,
  input  logic [arpbt_pkg::CNT_W-1:0]   out_entry_count
);
  import arpbt_pkg::*;

  // non-find commands answer in the next cycle
  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func != FUNC_FIND) |=> out_valid)
    else $error("add/remove result missing one cycle after transfer");

  // a find puts the block into its scan: busy, with no result yet
  a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_FIND) |=> (busy && !out_valid))
    else $error("find did not enter scan");

  // a result ends any busy period
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // failures carry slot index zero
  a_fail_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_slot_index == '0))
    else $error("nonzero slot index on failure");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_entry_count) <= ENTRIES))
    else $error("entry count beyond table size");

endmodule

bind arp_binding_table_unit arpbt_checker u_arpbt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_func         (in_func),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_slot_index  (out_slot_index),
  .out_entry_count (out_entry_count)
);

>>> bench/testbench.sv
// Self-checking bench for arp_binding_table_unit: directed and random add, find and
// remove commands, each reply compared with a table tracked inside the bench.
// Depends on arpbt_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
  import arpbt_pkg::*;

  // The spare opcode: the block must answer it without touching the table.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int POOL_SIZE    = 8;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] idx;
    logic [CNT_W-1:0]  count;
  } arp_reply_t;

  // Tracks the binding table as the block should hold it and keeps the replies
  // owed for commands that have been taken but not yet answered.
  class arp_table_tracker;
    bit             occupied[ENTRIES];
    bit [MAC_W-1:0] mac_tab[ENTRIES];
    bit [IP_W-1:0]  ip_tab[ENTRIES];
    int unsigned    live;
    arp_reply_t     pending_replies[$];
    int             errors;

    function new();
      live   = 0;
      errors = 0;
      foreach (occupied[i]) occupied[i] = 1'b0;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    // Apply one accepted command to the tracked table and queue its reply.
    function void note_command(logic [1:0] func, logic [MAC_W-1:0] mac,
                               logic [IP_W-1:0] ip, logic [SLOT_W-1:0] slot);
      arp_reply_t r;
      int         hit;
      r.status = ST_OK;
      r.idx    = '0;
      hit      = -1;
      case (func)
        FUNC_ADD: begin
          for (int i = 0; i < ENTRIES && hit < 0; i++)
            if (!occupied[i]) hit = i;
          if (live >= ENTRIES || hit < 0) begin
            r.status = ST_FULL;
          end else begin
            occupied[hit] = 1'b1;
            mac_tab[hit]  = mac;
            ip_tab[hit]   = ip;
            live++;
            r.idx = SLOT_W'(hit);
          end
        end
        FUNC_FIND: begin
          for (int i = 0; i < ENTRIES && hit < 0; i++)
            if (occupied[i] && mac_tab[i] == mac && ip_tab[i] == ip) hit = i;
          if (hit < 0) r.status = ST_NOT_FOUND;
          else r.idx = SLOT_W'(hit);
        end
        FUNC_REMOVE: begin
          if (int'(slot) < ENTRIES && occupied[slot]) begin
            occupied[slot] = 1'b0;
            if (live > 0) live--;
            r.idx = slot;
          end else begin
            r.status = ST_EMPTY;
          end
        end
        default: ;
      endcase
      r.count = CNT_W'(live);
      pending_replies.push_back(r);
    endfunction

    // Compare one reply from the block with the oldest one owed.
    function void check_reply(logic [1:0] status, logic [SLOT_W-1:0] idx,
                              logic [CNT_W-1:0] count);
      arp_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("reply with no command outstanding: status %0d slot_index %0d entry_count %0d",
               status, idx, count);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (idx !== want.idx) begin
        $error("slot_index: expected %0d, got %0d", want.idx, idx);
        errors++;
      end
      if (count !== want.count) begin
        $error("entry_count: expected %0d, got %0d", want.count, count);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n        = 1'b0;
  logic              start        = 1'b0;
  logic              busy;
  logic [1:0]        in_func      = FUNC_ADD;
  logic [MAC_W-1:0]  in_mac_addr  = '0;
  logic [IP_W-1:0]   in_ipv4_addr = '0;
  logic [SLOT_W-1:0] in_slot      = '0;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [SLOT_W-1:0] out_slot_index;
  logic [CNT_W-1:0]  out_entry_count;

  arp_table_tracker tracker = new();

  int unsigned cycle_count = 0;
  int          burst_left  = 0;

  // Address pairs that adds and finds share, so that finds actually hit and
  // duplicate pairs end up in the table.
  bit [MAC_W-1:0] pool_mac[POOL_SIZE];
  bit [IP_W-1:0]  pool_ip[POOL_SIZE];

  arp_binding_table_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_mac_addr     (in_mac_addr),
    .in_ipv4_addr    (in_ipv4_addr),
    .in_slot         (in_slot),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch both channels at every edge. Check the reply first: a command taken at
  // this same edge cannot be the one answered now.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        tracker.check_reply(out_status, out_slot_index, out_entry_count);
      if (start && !busy)
        tracker.note_command(in_func, in_mac_addr, in_ipv4_addr, in_slot);
    end
  end

  // Bound the run: a hung handshake or a lost reply ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom())};
  endfunction

  function automatic logic [IP_W-1:0] rand_ip();
    return 32'($urandom());
  endfunction

  // Sender gap: mostly back to back or short, now and then long, with bursts
  // of back-to-back commands mixed in.
  function automatic int next_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (roll < 4) begin
      burst_left = $urandom_range(20, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one command and hold it until the block takes it, then idle for a
  // random gap. start stays high across a zero gap so it is never dropped and
  // raised in one step.
  task automatic transfer_cmd(input logic [1:0] func, input logic [MAC_W-1:0] mac,
                              input logic [IP_W-1:0] ip, input logic [SLOT_W-1:0] slot);
    int gap;
    in_func      <= func;
    in_mac_addr  <= mac;
    in_ipv4_addr <= ip;
    in_slot      <= slot;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every owed reply has come back.
  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [1:0]        op;
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
    logic [SLOT_W-1:0] s;
    bit                filling;
    int                roll;
    int                pick;
    int                k;

    filling = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table cases first.
    transfer_cmd(FUNC_FIND, '1, '1, '0);            // miss on an empty table
    transfer_cmd(FUNC_REMOVE, '0, '0, 4'd0);        // remove of an empty slot
    transfer_cmd(FUNC_SPARE, '1, '1, '1);           // spare opcode changes nothing
    // Extreme addresses, plus a duplicate pair.
    transfer_cmd(FUNC_ADD, '1, '1, '1);             // -> slot 0
    transfer_cmd(FUNC_ADD, '0, '0, '0);             // -> slot 1
    transfer_cmd(FUNC_ADD, '1, '1, '0);             // duplicate -> slot 2
    transfer_cmd(FUNC_FIND, '1, '1, '0);            // lowest match: slot 0
    transfer_cmd(FUNC_FIND, '0, '0, '1);            // slot 1
    transfer_cmd(FUNC_FIND, '1, '0, '0);            // MAC matches, IPv4 does not
    transfer_cmd(FUNC_REMOVE, '1, '1, 4'd0);
    transfer_cmd(FUNC_FIND, '1, '1, '0);            // duplicate now found in slot 2
    transfer_cmd(FUNC_ADD, rand_mac(), rand_ip(), '0); // lowest free slot is 0 again
    // Fill the table, then push one more add against a full table.
    repeat (ENTRIES - 3) transfer_cmd(FUNC_ADD, rand_mac(), rand_ip(), '0);
    transfer_cmd(FUNC_ADD, '1, '0, '1);             // table full
    transfer_cmd(FUNC_FIND, '0, '1, '0);            // full-length scan, miss
    transfer_cmd(FUNC_REMOVE, '0, '0, 4'd15);       // highest slot
    transfer_cmd(FUNC_REMOVE, '1, '1, 4'd15);       // now already empty
    drain_replies();

    foreach (pool_mac[i]) begin
      pool_mac[i] = rand_mac();
      pool_ip[i]  = rand_ip();
    end

    // Random: alternate fill-heavy and drain-heavy stretches so the table swings
    // between empty and full, with finds aimed mostly at pairs that were added.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) filling = !filling;
      if (n % 200 == 199) drain_replies();
      if ($urandom_range(0, 15) == 0) begin
        k = $urandom_range(0, POOL_SIZE - 1);
        pool_mac[k] = rand_mac();
        pool_ip[k]  = rand_ip();
      end
      roll = $urandom_range(0, 99);
      k    = $urandom_range(0, POOL_SIZE - 1);
      mac  = rand_mac();
      ip   = rand_ip();
      s    = SLOT_W'($urandom_range(0, 15));
      if (roll < 3) begin
        op = FUNC_SPARE;
      end else if (roll < (filling ? 60 : 18)) begin
        op = FUNC_ADD;
        if ($urandom_range(0, 9) < 7) begin
          mac = pool_mac[k];
          ip  = pool_ip[k];
        end
      end else if (roll < (filling ? 78 : 68)) begin
        op = FUNC_REMOVE;
      end else begin
        op   = FUNC_FIND;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          mac = pool_mac[k];
          ip  = pool_ip[k];
        end else if (pick < 68) begin
          // near miss: flip one IPv4 bit
          mac = pool_mac[k];
          ip  = pool_ip[k] ^ (32'd1 << $urandom_range(0, 31));
        end else if (pick < 76) begin
          // near miss: flip one MAC bit
          mac = pool_mac[k] ^ (48'd1 << $urandom_range(0, 47));
          ip  = pool_ip[k];
        end
      end
      transfer_cmd(op, mac, ip, s);
    end

    // Wait out the last replies, then a little past the longest find.
    drain_replies();
    repeat (ENTRIES + 8) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> arp_binding_table_unit.f
hw/rtl/arpbt_pkg.sv
hw/rtl/arpbt_free_enc.sv
hw/rtl/arp_binding_table_unit.sv
hw/rtl/arpbt_checker.sv
bench/testbench.sv
